// ===== sv/lcd_rect_and_glyph_draw_engine_assert.svh =====
// Assertion macros shared by the draw engine modules.
// Each macro expects the signals clk and rst_n in the scope where it is used.
`ifndef LCD_RECT_AND_GLYPH_DRAW_ENGINE_ASSERT_SVH
`define LCD_RECT_AND_GLYPH_DRAW_ENGINE_ASSERT_SVH

// Check a condition that must hold in the same cycle as its trigger
`define LRGE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition that must hold in the cycle after its trigger
`define LRGE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lrge_pkg.sv =====
// Shared types and constants of the rectangle and glyph draw engine.
// No dependencies; used by the controller, the datapath and the top level.
package lrge_pkg;

    // Font memory geometry
    localparam int FONT_BYTES = 4096;
    localparam int FONT_AW    = $clog2(FONT_BYTES);

    // Full-screen window restored after every draw
    localparam logic [15:0] SCREEN_X_MAX = 16'd239;
    localparam logic [15:0] SCREEN_Y_MAX = 16'd319;

    // Controller opcodes
    localparam logic [7:0] CMD_COL_ADDR = 8'h2A;
    localparam logic [7:0] CMD_ROW_ADDR = 8'h2B;
    localparam logic [7:0] CMD_MEM_WR   = 8'h2C;

    // Offset of the first glyph in font memory
    localparam logic [11:0] GLYPH_BASE_OFS = 12'd4;

    // Item modes
    localparam logic [1:0] MODE_FILL = 2'd0;
    localparam logic [1:0] MODE_CHAR = 2'd1;
    localparam logic [1:0] MODE_FONT = 2'd2;
    localparam logic [1:0] MODE_ADV  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BUSY     = 2'd1;
    localparam logic [1:0] ST_LOW_CHAR = 2'd2;
    localparam logic [1:0] ST_IDLE_ADV = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_FG_COLOR     = 3'd0;
    localparam logic [2:0] CFG_BG_COLOR     = 3'd1;
    localparam logic [2:0] CFG_GLYPH_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_GLYPH_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_FIRST_CHAR   = 3'd4;

    // Input item as packed on s_tdata, last field in the low bits
    typedef struct packed {
        logic [3:0]  pad;
        logic [7:0]  font_data;
        logic [11:0] font_addr;
        logic [7:0]  char_code;
        logic [11:0] y_end;
        logic [11:0] x_end;
        logic [11:0] y_start;
        logic [11:0] x_start;
    } in_item_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic mul;
        logic exec;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

// ===== sv/lrge_ctrl.sv =====
// Item sequencer of the draw engine: accept, prepare, multiply, commit.
// Depends on lrge_pkg and the assertion macro header.
`include "lcd_rect_and_glyph_draw_engine_assert.svh"

module lrge_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  lrge_pkg::dp_stat_t  stat,
    output lrge_pkg::ctrl_cmd_t cmd
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_PREP = 2'd1;
    localparam logic [1:0] C_MUL  = 2'd2;
    localparam logic [1:0] C_EXEC = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Take an item only when no other item is in flight
    assign s_tready = (state_reg == C_IDLE);

    // Issue one command per state; commit waits for a free output register
    always_comb
    begin
        cmd.load   = s_tvalid && (state_reg == C_IDLE);
        cmd.prep   = (state_reg == C_PREP);
        cmd.mul    = (state_reg == C_MUL);
        cmd.exec   = (state_reg == C_EXEC) && stat.out_free;
        state_next = state_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = C_PREP;
                end
            end
            C_PREP:  state_next = C_MUL;
            C_MUL:   state_next = C_EXEC;
            C_EXEC:
            begin
                if (cmd.exec)
                begin
                    state_next = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    // Advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `LRGE_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0({cmd.load, cmd.prep, cmd.mul, cmd.exec}),
        "more than one datapath command in a cycle")
    `LRGE_ASSERT_NEXT(a_load_starts, cmd.load, cmd.prep,
        "accepted transaction did not enter the prepare step")
    `LRGE_ASSERT_NEXT(a_exec_frees, cmd.exec, s_tready,
        "sequencer did not return to accept after commit")

endmodule

// ===== sv/lrge_datapath.sv =====
// Datapath of the draw engine: input latch, window and glyph arithmetic,
// font memory, draw state and output register. Depends on lrge_pkg and the macro header.
`include "lcd_rect_and_glyph_draw_engine_assert.svh"

module lrge_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  lrge_pkg::ctrl_cmd_t cmd,
    output lrge_pkg::dp_stat_t  stat,
    input  logic [1:0]          in_mode,
    input  logic [79:0]         in_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output logic [3:0]          m_tuser
);

    localparam int AW = lrge_pkg::FONT_AW;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PIXELS  = 2'd2;
    localparam logic [1:0] PH_TRAILER = 2'd3;

    // Configuration registers
    logic [15:0] fg_color_reg;
    logic [15:0] bg_color_reg;
    logic [6:0]  glyph_width_reg;
    logic [6:0]  glyph_height_reg;
    logic [7:0]  first_char_reg;

    // Latched item
    logic [1:0]         mode_reg;
    lrge_pkg::in_item_t item_reg;

    // Prepare stage
    logic [11:0] x_lo_reg, x_hi_reg, y_lo_reg, y_hi_reg;
    logic [12:0] dx_reg, dy_reg;
    logic [10:0] bytes_per_glyph_reg;
    logic [7:0]  char_off_reg;
    logic        char_low_reg;
    logic [15:0] glyph_x_end_reg, glyph_y_end_reg;

    // Multiply stage
    logic [24:0]   fill_count_reg;
    logic [AW-1:0] glyph_base_reg;

    // Font memory
    logic [7:0] font_mem [lrge_pkg::FONT_BYTES];
    logic [7:0] font_q_reg;

    // Draw state
    logic [1:0]    phase_reg, phase_next;
    logic [3:0]    header_step_reg, header_step_next;
    logic [24:0]   pixels_left_reg, pixels_left_next;
    logic [AW-1:0] glyph_addr_reg, glyph_addr_next;
    logic [7:0]    glyph_byte_reg, glyph_byte_next;
    logic [2:0]    bit_index_reg, bit_index_next;
    logic          low_half_reg, low_half_next;
    logic [15:0]   window_ends_reg [4];
    logic [15:0]   window_ends_next [4];
    logic          is_glyph_reg, is_glyph_next;

    // Output register
    logic       m_tvalid_reg;
    logic       has_byte_reg, is_data_reg, last_reg;
    logic [7:0] out_byte_reg;
    logic [1:0] status_reg;

    // Result of the commit step
    logic       res_has, res_data, res_last;
    logic [7:0] res_byte;
    logic [1:0] res_status;

    // Combinational helpers
    logic [3:0]  bytes_per_row;
    logic [25:0] fill_prod;
    logic [18:0] glyph_prod;
    logic [15:0] ends_sel [4];
    logic        font_load;
    logic [7:0]  cur_byte;
    logic [15:0] color;
    logic        font_we;

    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign bytes_per_row = glyph_width_reg[6:3];
    assign fill_prod     = {13'd0, dx_reg} * {13'd0, dy_reg};
    assign glyph_prod    = {11'd0, char_off_reg} * {8'd0, bytes_per_glyph_reg};
    assign font_we       = cmd.exec && (mode_reg == lrge_pkg::MODE_FONT);

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_color_reg     <= 16'hFFFF;
            bg_color_reg     <= 16'h0000;
            glyph_width_reg  <= 7'd16;
            glyph_height_reg <= 7'd16;
            first_char_reg   <= 8'd32;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lrge_pkg::CFG_FG_COLOR:     fg_color_reg     <= cfg_data;
                lrge_pkg::CFG_BG_COLOR:     bg_color_reg     <= cfg_data;
                lrge_pkg::CFG_GLYPH_WIDTH:  glyph_width_reg  <= cfg_data[6:0];
                lrge_pkg::CFG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data[6:0];
                lrge_pkg::CFG_FIRST_CHAR:   first_char_reg   <= cfg_data[7:0];
                default:                    ;
            endcase
        end
    end

    // Latch the item, order the corners, form glyph window and byte count, multiply for count and base
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_mode;
            item_reg <= lrge_pkg::in_item_t'(in_data);
        end
        if (cmd.prep)
        begin
            x_lo_reg <= (item_reg.x_start > item_reg.x_end) ? item_reg.x_end : item_reg.x_start;
            x_hi_reg <= (item_reg.x_start > item_reg.x_end) ? item_reg.x_start : item_reg.x_end;
            y_lo_reg <= (item_reg.y_start > item_reg.y_end) ? item_reg.y_end : item_reg.y_start;
            y_hi_reg <= (item_reg.y_start > item_reg.y_end) ? item_reg.y_start : item_reg.y_end;
            dx_reg   <= (item_reg.x_start > item_reg.x_end)
                      ? ({1'b0, item_reg.x_start} - {1'b0, item_reg.x_end} + 13'd1)
                      : ({1'b0, item_reg.x_end} - {1'b0, item_reg.x_start} + 13'd1);
            dy_reg   <= (item_reg.y_start > item_reg.y_end)
                      ? ({1'b0, item_reg.y_start} - {1'b0, item_reg.y_end} + 13'd1)
                      : ({1'b0, item_reg.y_end} - {1'b0, item_reg.y_start} + 13'd1);
            bytes_per_glyph_reg <= {7'd0, bytes_per_row} * {4'd0, glyph_height_reg};
            char_off_reg        <= item_reg.char_code - first_char_reg;
            char_low_reg        <= (item_reg.char_code < first_char_reg);
            glyph_x_end_reg     <= {4'd0, item_reg.x_start} + {9'd0, glyph_width_reg} - 16'd1;
            glyph_y_end_reg     <= {4'd0, item_reg.y_start} + {9'd0, glyph_height_reg} - 16'd1;
        end
        if (cmd.mul)
        begin
            fill_count_reg <= fill_prod[24:0];
            glyph_base_reg <= glyph_prod[AW-1:0] + GLYPH_BASE_OFS_W;
        end
    end

    localparam logic [AW-1:0] GLYPH_BASE_OFS_W = AW'(lrge_pkg::GLYPH_BASE_OFS);

    // Write font bytes on commit; read the current glyph byte every cycle
    always_ff @(posedge clk)
    begin
        if (font_we)
        begin
            font_mem[item_reg.font_addr[AW-1:0]] <= item_reg.font_data;
        end
        font_q_reg <= font_mem[glyph_addr_reg];
    end

    // Pick the window being sent: the draw window or the full screen
    always_comb
    begin
        if (phase_reg == PH_TRAILER)
        begin
            ends_sel[0] = 16'd0;
            ends_sel[1] = lrge_pkg::SCREEN_X_MAX;
            ends_sel[2] = 16'd0;
            ends_sel[3] = lrge_pkg::SCREEN_Y_MAX;
        end
        else
        begin
            ends_sel = window_ends_reg;
        end
    end

    // Glyph byte and pixel color of the current pixel
    assign font_load = is_glyph_reg && !low_half_reg && (bit_index_reg == 3'd0);
    assign cur_byte  = font_load ? font_q_reg : glyph_byte_reg;
    assign color     = (is_glyph_reg && !cur_byte[3'd7 - bit_index_reg])
                     ? bg_color_reg : fg_color_reg;

    // Commit step: next draw state and the result of this item
    always_comb
    begin
        phase_next       = phase_reg;
        header_step_next = header_step_reg;
        pixels_left_next = pixels_left_reg;
        glyph_addr_next  = glyph_addr_reg;
        glyph_byte_next  = glyph_byte_reg;
        bit_index_next   = bit_index_reg;
        low_half_next    = low_half_reg;
        window_ends_next = window_ends_reg;
        is_glyph_next    = is_glyph_reg;
        res_has          = 1'b0;
        res_data         = 1'b0;
        res_byte         = 8'd0;
        res_last         = 1'b0;
        res_status       = lrge_pkg::ST_OK;
        case (mode_reg)
            lrge_pkg::MODE_FILL, lrge_pkg::MODE_CHAR:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    res_status = lrge_pkg::ST_BUSY;
                end
                else if ((mode_reg == lrge_pkg::MODE_CHAR) && char_low_reg)
                begin
                    res_status = lrge_pkg::ST_LOW_CHAR;
                end
                else
                begin
                    phase_next       = PH_HEADER;
                    header_step_next = 4'd0;
                    low_half_next    = 1'b0;
                    bit_index_next   = 3'd0;
                    if (mode_reg == lrge_pkg::MODE_FILL)
                    begin
                        window_ends_next[0] = {4'd0, x_lo_reg};
                        window_ends_next[1] = {4'd0, x_hi_reg};
                        window_ends_next[2] = {4'd0, y_lo_reg};
                        window_ends_next[3] = {4'd0, y_hi_reg};
                        pixels_left_next    = fill_count_reg;
                        is_glyph_next       = 1'b0;
                    end
                    else
                    begin
                        window_ends_next[0] = {4'd0, item_reg.x_start};
                        window_ends_next[1] = glyph_x_end_reg;
                        window_ends_next[2] = {4'd0, item_reg.y_start};
                        window_ends_next[3] = glyph_y_end_reg;
                        pixels_left_next    = {11'd0, bytes_per_glyph_reg, 3'd0};
                        glyph_addr_next     = glyph_base_reg;
                        is_glyph_next       = 1'b1;
                    end
                end
            end
            lrge_pkg::MODE_FONT:
            begin
                res_status = lrge_pkg::ST_OK;
            end
            lrge_pkg::MODE_ADV:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    res_status = lrge_pkg::ST_IDLE_ADV;
                end
                else if (phase_reg == PH_PIXELS)
                begin
                    res_has  = 1'b1;
                    res_data = 1'b1;
                    res_byte = low_half_reg ? color[7:0] : color[15:8];
                    if (font_load)
                    begin
                        glyph_byte_next = font_q_reg;
                    end
                    if (!low_half_reg)
                    begin
                        low_half_next = 1'b1;
                    end
                    else
                    begin
                        low_half_next    = 1'b0;
                        pixels_left_next = pixels_left_reg - 25'd1;
                        if (is_glyph_reg)
                        begin
                            bit_index_next = bit_index_reg + 3'd1;
                            if (bit_index_reg == 3'd7)
                            begin
                                glyph_addr_next = glyph_addr_reg + {{(AW-1){1'b0}}, 1'b1};
                            end
                        end
                        if (pixels_left_reg == 25'd1)
                        begin
                            phase_next       = PH_TRAILER;
                            header_step_next = 4'd0;
                        end
                    end
                end
                else
                begin
                    // Window sequence: column command, X ends, row command, Y ends, write
                    res_has  = 1'b1;
                    res_data = 1'b1;
                    case (header_step_reg)
                        4'd0:
                        begin
                            res_byte = lrge_pkg::CMD_COL_ADDR;
                            res_data = 1'b0;
                        end
                        4'd1:    res_byte = ends_sel[0][15:8];
                        4'd2:    res_byte = ends_sel[0][7:0];
                        4'd3:    res_byte = ends_sel[1][15:8];
                        4'd4:    res_byte = ends_sel[1][7:0];
                        4'd5:
                        begin
                            res_byte = lrge_pkg::CMD_ROW_ADDR;
                            res_data = 1'b0;
                        end
                        4'd6:    res_byte = ends_sel[2][15:8];
                        4'd7:    res_byte = ends_sel[2][7:0];
                        4'd8:    res_byte = ends_sel[3][15:8];
                        4'd9:    res_byte = ends_sel[3][7:0];
                        default:
                        begin
                            res_byte = lrge_pkg::CMD_MEM_WR;
                            res_data = 1'b0;
                        end
                    endcase
                    if (header_step_reg >= 4'd10)
                    begin
                        header_step_next = 4'd0;
                        if (phase_reg == PH_TRAILER)
                        begin
                            res_last   = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = (pixels_left_reg != 25'd0) ? PH_PIXELS : PH_TRAILER;
                        end
                    end
                    else
                    begin
                        header_step_next = header_step_reg + 4'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Hold draw state; update it on commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            header_step_reg <= 4'd0;
            pixels_left_reg <= 25'd0;
            glyph_addr_reg  <= '0;
            glyph_byte_reg  <= 8'd0;
            bit_index_reg   <= 3'd0;
            low_half_reg    <= 1'b0;
            window_ends_reg <= '{default: 16'd0};
            is_glyph_reg    <= 1'b0;
        end
        else if (cmd.exec)
        begin
            phase_reg       <= phase_next;
            header_step_reg <= header_step_next;
            pixels_left_reg <= pixels_left_next;
            glyph_addr_reg  <= glyph_addr_next;
            glyph_byte_reg  <= glyph_byte_next;
            bit_index_reg   <= bit_index_next;
            low_half_reg    <= low_half_next;
            window_ends_reg <= window_ends_next;
            is_glyph_reg    <= is_glyph_next;
        end
    end

    // Output valid: set on commit, drop when the transaction is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            has_byte_reg <= res_has;
            is_data_reg  <= res_data;
            out_byte_reg <= res_byte;
            last_reg     <= res_last;
            status_reg   <= res_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = {status_reg, is_data_reg, has_byte_reg};

    `LRGE_ASSERT_NOW(a_pixels_nonzero, phase_reg == PH_PIXELS, pixels_left_reg != 25'd0,
        "pixel phase with no pixels left")
    `LRGE_ASSERT_NOW(a_header_range, phase_reg != PH_PIXELS, header_step_reg <= 4'd10,
        "window sequence step out of range")
    `LRGE_ASSERT_NOW(a_empty_result, m_tvalid_reg && !has_byte_reg,
        (out_byte_reg == 8'd0) && !last_reg && !is_data_reg,
        "result without a byte carries byte fields")

endmodule

// ===== sv/lcd_rect_and_glyph_draw_engine.sv =====
// Rectangle fill and glyph draw engine producing display-controller bytes.
// Each item passes from acceptance to result through latch, prepare, multiply and commit;
// the item sequencer takes no new item until the last one commits, and output back-pressure
// stalls the commit step. The output register lets a new item enter while a result waits.
// rst_n clears draw state and loads register defaults; font memory is not cleared.
module lcd_rect_and_glyph_draw_engine (
    input  logic        clk,
    input  logic        rst_n,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // x_start, y_start, x_end, y_end, char_code,
                                   // font_addr, font_data, zero pad (low bit first)
    input  logic [1:0]  s_tuser,   // mode
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast,
    output logic [3:0]  m_tuser,   // has_byte, is_data, status[1:0] (low bit first)
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    lrge_pkg::ctrl_cmd_t cmd;
    lrge_pkg::dp_stat_t  stat;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    lrge_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lrge_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_mode   (s_tuser),
        .in_data   (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
